### hdl/het_pkg.sv
// Package for the Hamming edge taper: widths, pipeline slot map, register codes
// and the weight table built at elaboration. No dependencies.
package het_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS      = 24;
    localparam int ANGLE_BITS       = 10;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int INDEX_BITS       = 16;
    localparam int LEN_BITS         = 16;
    localparam int SIDE_LEN_BITS    = 15;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 16;

    // Derived widths
    localparam int WEIGHT_BITS = WEIGHT_FRAC_BITS + 1;
    localparam int Q_BITS      = ANGLE_BITS + 1;
    localparam int ANGLE_FULL  = 1 << ANGLE_BITS;
    localparam int ANGLE_HALF  = ANGLE_FULL / 2;
    localparam int NUM_BITS    = LEN_BITS + ANGLE_BITS + 1;

    // Divider: quotient bits resolved per stage
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = (Q_BITS + DIV_STEP - 1) / DIV_STEP;

    // Pipeline slot map
    localparam int SLOT_ROM  = DIV_STAGES + 1;
    localparam int SLOT_WMUL = DIV_STAGES + 2;
    localparam int SLOT_SMUL = DIV_STAGES + 3;
    localparam int SLOT_OUT  = DIV_STAGES + 4;
    localparam int NSLOTS    = DIV_STAGES + 5;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE  = WEIGHT_BITS'(1) << WEIGHT_FRAC_BITS;
    localparam logic [WEIGHT_FRAC_BITS-1:0] WEIGHT_HALF =
        WEIGHT_FRAC_BITS'(1) << (WEIGHT_FRAC_BITS - 1);

    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef weight_t weight_rom_t [0:ANGLE_FULL];

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SIDE_LEN   = 2'd0,
        REG_BOTTOM_LEN = 2'd1,
        REG_TRACES     = 2'd2,
        REG_SAMPLES    = 2'd3
    } cfg_reg_e;

    // Divider lane input word
    typedef struct packed {
        logic [NUM_BITS-1:0] num;
        logic [LEN_BITS-1:0] len;
        logic                active;
    } lane_in_t;

    // Cosine arithmetic, elaboration only
    localparam longint unsigned COS_ONE   = 64'd1 << 30;
    localparam longint unsigned PI_Q30    = 64'd3373259426;
    localparam longint unsigned WDEN      = 64'd100 << 30;
    localparam longint unsigned WDEN_HALF = WDEN / 2;

    // Truncating unsigned quotient by shift and subtract
    function automatic longint unsigned div_u64(input longint unsigned n,
                                                input longint unsigned d);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], n[b]};
            if (rem >= d)
            begin
                rem    = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // cos(pi*q/2^ANGLE_BITS) in Q2.30 for the first quarter turn
    function automatic longint cos_quarter(input longint unsigned q);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (PI_Q30 * q + (64'd1 << (ANGLE_BITS - 1))) >> ANGLE_BITS;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = COS_ONE;
        acc  = longint'(COS_ONE);
        for (int k = 1; k <= 9; k++)
        begin
            term = div_u64((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) != 0)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return acc;
    endfunction

    function automatic weight_t hamming_weight(input longint unsigned q);
        longint          c;
        longint          num;
        longint unsigned w;
        if (q > ANGLE_HALF)
            c = -cos_quarter(ANGLE_FULL - q);
        else
            c = cos_quarter(q);
        num = 54 * longint'(COS_ONE) + 46 * c;
        if (num < 0)
            num = 0;
        w = div_u64((64'(num) << WEIGHT_FRAC_BITS) + WDEN_HALF, WDEN);
        if (w > (64'd1 << WEIGHT_FRAC_BITS))
            w = 64'd1 << WEIGHT_FRAC_BITS;
        return WEIGHT_BITS'(w);
    endfunction

    function automatic weight_rom_t build_weight_rom();
        weight_rom_t rom;
        for (int q = 0; q <= ANGLE_FULL; q++)
        begin
            rom[q] = hamming_weight(longint'(q));
        end
        return rom;
    endfunction

    localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

endpackage

### hdl/het_lane.sv
// One weight lane: pipelined restoring divider for the angle index, then
// the registered weight table read. Depends on het_pkg.
module het_lane (
    input  logic                             clk,
    input  logic [het_pkg::DIV_STAGES:0]     adv,
    input  het_pkg::lane_in_t                lane_in,
    output het_pkg::weight_t                 weight
);
    import het_pkg::*;

    logic [NUM_BITS-1:0] rem_reg [0:DIV_STAGES-2];
    logic [LEN_BITS-1:0] len_reg [0:DIV_STAGES-2];
    logic [Q_BITS-1:0]   quo_reg [0:DIV_STAGES-1];
    logic                act_reg [0:DIV_STAGES-1];
    weight_t             weight_reg;

    logic [Q_BITS-1:0]   rom_idx;

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++)
        begin : g_div
            logic [NUM_BITS-1:0] rem_in;
            logic [LEN_BITS-1:0] len_in;
            logic [Q_BITS-1:0]   quo_in;
            logic                act_in;
            logic [NUM_BITS-1:0] rem_next;
            logic [Q_BITS-1:0]   quo_next;
            logic [NUM_BITS:0]   trial;

            if (j == 0)
            begin : g_first
                assign rem_in = lane_in.num;
                assign len_in = lane_in.len;
                assign quo_in = '0;
                assign act_in = lane_in.active;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign len_in = len_reg[j-1];
                assign quo_in = quo_reg[j-1];
                assign act_in = act_reg[j-1];
            end

            // Resolve up to DIV_STEP quotient bits, most significant first
            always_comb
            begin
                rem_next = rem_in;
                quo_next = quo_in;
                trial    = '0;
                for (int b = 0; b < DIV_STEP; b++)
                begin
                    if (j * DIV_STEP + b < Q_BITS)
                    begin
                        trial = {1'b0, rem_next}
                              - (((NUM_BITS + 1)'(len_in)) << (Q_BITS - 1 - (j * DIV_STEP + b)));
                        if (!trial[NUM_BITS])
                        begin
                            rem_next = trial[NUM_BITS-1:0];
                            quo_next[Q_BITS - 1 - (j * DIV_STEP + b)] = 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[j])
                begin
                    quo_reg[j] <= quo_next;
                    act_reg[j] <= act_in;
                end
            end

            if (j < DIV_STAGES - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (adv[j])
                    begin
                        rem_reg[j] <= rem_next;
                        len_reg[j] <= len_in;
                    end
                end
            end
        end
    endgenerate

    // Hold the index inside the table for an unused lane
    assign rom_idx = (quo_reg[DIV_STAGES-1] > Q_BITS'(ANGLE_FULL)) ?
                     Q_BITS'(ANGLE_FULL) : quo_reg[DIV_STAGES-1];

    always_ff @(posedge clk)
    begin
        if (adv[DIV_STAGES])
        begin
            weight_reg <= act_reg[DIV_STAGES-1] ? WEIGHT_ROM[rom_idx] : WEIGHT_ONE;
        end
    end

    assign weight = weight_reg;

endmodule

### hdl/hamming_edge_taper_top.sv
// Top level of the Hamming edge taper: configuration registers, index prep,
// two weight lanes, weight and sample multipliers. Depends on het_pkg, het_lane.
//
//  channel  direction  handshake               word
//  cfg      in         cfg_write (no wait)     cfg_index, cfg_data
//  in       in         in_valid / in_stall     trace_index, sample_index, sample_value
//  out      out        out_valid / out_stall   tapered_value
//
// One word enters per cycle while in_stall is low. From acceptance to out_valid a word
// passes one prep slot, six divider slots (up to two quotient bits each), the table
// read, the weight multiply, the sample multiply and the output register.
// rst_n clears the valid bits and loads the register defaults (taper lengths 0,
// counts 1). A stall holds only the slots that are full behind it; empty slots
// keep filling, so input is taken while a finished word waits on the output.
module hamming_edge_taper_top (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_write,
    input  logic [het_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
    input  logic [het_pkg::CFG_DATA_BITS-1:0]            cfg_data,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic [het_pkg::INDEX_BITS-1:0]               trace_index,
    input  logic [het_pkg::INDEX_BITS-1:0]               sample_index,
    input  logic signed [het_pkg::SAMPLE_BITS-1:0]       sample_value,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [het_pkg::SAMPLE_BITS-1:0]       tapered_value
);
    import het_pkg::*;

    // Configuration registers
    logic [SIDE_LEN_BITS-1:0] side_len_reg;
    logic [LEN_BITS-1:0]      bottom_len_reg;
    logic [INDEX_BITS-1:0]    traces_reg;
    logic [INDEX_BITS-1:0]    samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_len_reg   <= '0;
            bottom_len_reg <= '0;
            traces_reg     <= INDEX_BITS'(1);
            samples_reg    <= INDEX_BITS'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_SIDE_LEN:   side_len_reg   <= cfg_data[SIDE_LEN_BITS-1:0];
                REG_BOTTOM_LEN: bottom_len_reg <= cfg_data[LEN_BITS-1:0];
                REG_TRACES:     traces_reg     <= cfg_data[INDEX_BITS-1:0];
                REG_SAMPLES:    samples_reg    <= cfg_data[INDEX_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Slot valid bits and load enables. A slot loads when it is empty or its
    // successor loads, so bubbles close up under a stall.
    logic [NSLOTS-1:0] valid_reg;
    logic [NSLOTS-1:0] valid_next;
    logic [NSLOTS-1:0] load_en;

    always_comb
    begin
        load_en[NSLOTS-1] = !valid_reg[NSLOTS-1] || !out_stall;
        for (int k = NSLOTS - 2; k >= 0; k--)
        begin
            load_en[k] = !valid_reg[k] || load_en[k+1];
        end
        valid_next[0] = load_en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NSLOTS; k++)
        begin
            valid_next[k] = load_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall  = !load_en[0];
    assign out_valid = valid_reg[SLOT_OUT];

    // Prep: taper membership, taper position m (saturated to the length),
    // and the rounded dividend m*2^ANGLE_BITS + L/2 for each lane.
    logic [INDEX_BITS:0]     side_reach;
    logic [INDEX_BITS+1:0]   side_over;
    logic                    side_left;
    logic                    side_right;
    logic [SIDE_LEN_BITS-1:0] side_m_right;
    logic [LEN_BITS-1:0]     side_m;
    logic [LEN_BITS-1:0]     side_len;
    logic [INDEX_BITS:0]     bot_reach;
    logic [INDEX_BITS+1:0]   bot_over;
    logic                    bot_hit;
    logic [LEN_BITS-1:0]     bot_m;
    logic                    sample_neg;
    logic [SAMPLE_BITS-1:0]  sample_mag;
    lane_in_t                side_in_next;
    lane_in_t                bot_in_next;

    always_comb
    begin
        side_len   = {1'b0, side_len_reg};
        side_left  = trace_index < side_len;
        side_reach = {1'b0, trace_index} + {2'b00, side_len_reg};
        side_right = side_reach >= {1'b0, traces_reg};
        side_over  = {1'b0, side_reach} + (INDEX_BITS + 2)'(1) - {2'b00, traces_reg};
        side_m_right = (side_over > (INDEX_BITS + 2)'(side_len_reg)) ?
                       side_len_reg : side_over[SIDE_LEN_BITS-1:0];
        side_m     = side_left ? (side_len - trace_index) : {1'b0, side_m_right};

        bot_reach  = {1'b0, sample_index} + {1'b0, bottom_len_reg};
        bot_hit    = bot_reach >= {1'b0, samples_reg};
        bot_over   = {1'b0, bot_reach} + (INDEX_BITS + 2)'(1) - {2'b00, samples_reg};
        bot_m      = (bot_over > {2'b00, bottom_len_reg}) ?
                     bottom_len_reg : bot_over[LEN_BITS-1:0];

        side_in_next.num    = {1'b0, side_m, {ANGLE_BITS{1'b0}}}
                            + NUM_BITS'(side_len >> 1);
        side_in_next.len    = side_len;
        side_in_next.active = (side_len_reg != '0) && (side_left || side_right);

        bot_in_next.num     = {1'b0, bot_m, {ANGLE_BITS{1'b0}}}
                            + NUM_BITS'(bottom_len_reg >> 1);
        bot_in_next.len     = bottom_len_reg;
        bot_in_next.active  = (bottom_len_reg != '0) && bot_hit;

        // Most negative sample maps to its own magnitude 2^(SAMPLE_BITS-1)
        sample_neg = sample_value[SAMPLE_BITS-1];
        sample_mag = sample_neg ? ((~sample_value) + 1'b1) : sample_value;
    end

    lane_in_t side_in_reg;
    lane_in_t bot_in_reg;

    always_ff @(posedge clk)
    begin
        if (load_en[0])
        begin
            side_in_reg <= side_in_next;
            bot_in_reg  <= bot_in_next;
        end
    end

    // Sign and magnitude ride alongside the lanes
    logic [SAMPLE_BITS-1:0] mag_reg [0:SLOT_SMUL];
    logic                   neg_reg [0:SLOT_SMUL];

    always_ff @(posedge clk)
    begin
        if (load_en[0])
        begin
            mag_reg[0] <= sample_mag;
            neg_reg[0] <= sample_neg;
        end
    end

    genvar s;
    generate
        for (s = 1; s <= SLOT_SMUL; s++)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (load_en[s])
                begin
                    mag_reg[s] <= mag_reg[s-1];
                    neg_reg[s] <= neg_reg[s-1];
                end
            end
        end
    endgenerate

    // Weight lanes: dividers and table reads
    weight_t side_weight;
    weight_t bot_weight;

    het_lane u_side_lane (
        .clk     (clk),
        .adv     (load_en[SLOT_ROM:1]),
        .lane_in (side_in_reg),
        .weight  (side_weight)
    );

    het_lane u_bot_lane (
        .clk     (clk),
        .adv     (load_en[SLOT_ROM:1]),
        .lane_in (bot_in_reg),
        .weight  (bot_weight)
    );

    // Combined weight, rounded to WEIGHT_FRAC_BITS
    logic [2*WEIGHT_BITS-1:0] wprod;
    weight_t                  comb_w_reg;

    assign wprod = side_weight * bot_weight + (2*WEIGHT_BITS)'(WEIGHT_HALF);

    always_ff @(posedge clk)
    begin
        if (load_en[SLOT_WMUL])
            comb_w_reg <= WEIGHT_BITS'(wprod >> WEIGHT_FRAC_BITS);
    end

    // Scale the magnitude, round half away from zero
    logic [SAMPLE_BITS+WEIGHT_BITS-1:0] sprod;
    logic [SAMPLE_BITS-1:0]             rnd_reg;

    assign sprod = mag_reg[SLOT_WMUL] * comb_w_reg
                 + (SAMPLE_BITS + WEIGHT_BITS)'(WEIGHT_HALF);

    always_ff @(posedge clk)
    begin
        if (load_en[SLOT_SMUL])
            rnd_reg <= sprod[WEIGHT_FRAC_BITS +: SAMPLE_BITS];
    end

    // Clamp to the input magnitude, restore the sign
    logic [SAMPLE_BITS-1:0] clamped;
    logic [SAMPLE_BITS-1:0] out_reg;

    assign clamped = (rnd_reg > mag_reg[SLOT_SMUL]) ? mag_reg[SLOT_SMUL] : rnd_reg;

    always_ff @(posedge clk)
    begin
        if (load_en[SLOT_OUT])
            out_reg <= neg_reg[SLOT_SMUL] ? ((~clamped) + 1'b1) : clamped;
    end

    assign tapered_value = out_reg;

    // Checks on the slot control and the weight range
    a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output slot");

    a_full_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && out_stall) |-> in_stall)
        else $error("input taken while every slot is full and stalled");

    a_weight_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[SLOT_WMUL] |-> (comb_w_reg <= WEIGHT_ONE))
        else $error("combined weight above one");

    a_slot_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[SLOT_SMUL] && load_en[SLOT_OUT]) |=> valid_reg[SLOT_OUT])
        else $error("word lost between multiplier and output");

endmodule
